// ----- rtl/prime_factor_dft10_top_macros.svh -----
// Assertion macros shared by the ten-point DFT RTL.
// No dependencies; included inside module bodies.
`ifndef PRIME_FACTOR_DFT10_TOP_MACROS_SVH
`define PRIME_FACTOR_DFT10_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PFD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PFD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/pfd10_pkg.sv -----
// Types and constants of the ten-point prime factor DFT.
// No dependencies.
`default_nettype none
package pfd10_pkg;
   localparam int NPTS = 10;
   localparam int OUT_BITS = 20;
   localparam int ACC_BITS = 26;
   localparam logic signed [15:0] Q_C72 = 16'sd10126;
   localparam logic signed [15:0] Q_S72 = 16'sd31164;
   localparam logic signed [15:0] Q_C144 = -16'sd26510;
   localparam logic signed [15:0] Q_S144 = 16'sd19261;
   localparam logic signed [OUT_BITS-1:0] OUT_MAX = 20'sh7FFFF;
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = 20'sh80000;

   // One queued block: ten complex samples plus the direction captured.
   typedef struct packed {
      logic                        inv;
      logic [NPTS-1:0][47:0]       smp;
   } blk_type;
endpackage
`default_nettype wire

// ----- rtl/pfd10_if.sv -----
// Valid/ready stream interfaces for samples and results.
// No dependencies.
`default_nettype none
interface pfd10_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] sample_re;
   logic signed [15:0] sample_im;
   modport source (output valid, sample_re, sample_im, input ready);
   modport sink (input valid, sample_re, sample_im, output ready);
endinterface

interface pfd10_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] bin_index;
   logic signed [19:0] out_re;
   logic signed [19:0] out_im;
   logic last;
   modport source (output valid, bin_index, out_re, out_im, last, input ready);
   modport sink (input valid, bin_index, out_re, out_im, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/prime_factor_dft10_top.sv -----
// Top level of the ten-point Good-Thomas DFT.
// Depends on pfd10_pkg, pfd10_if, pfd10_front, pfd10_back.
`default_nettype none
// Ten-point DFT, Good-Thomas. Samples enter one per cycle on req, but the
// tenth sample of a block waits for queue room; after it the block is queued
// (two blocks deep). The back end takes a queued block, runs two 5-point DFTs
// (four product steps each on the shared four-multiplier unit, then one sum
// step), combines the halves into bins, then streams ten bins on rsp with last
// on bin nine. Loading the next block overlaps the work on the current one.
// csr_we writes direction (0 forward, 1 inverse); it is sampled when the tenth
// sample of a block is taken.
module prime_factor_dft10_top #(parameter int SAMPLE_BITS = 16) (
   input  wire logic clock,
   input  wire logic reset,
   pfd10_req_if.sink   req,
   pfd10_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic [0:0] csr_wdata
);
   import pfd10_pkg::*;

   logic dir_ff;
   logic q_valid, q_pop;
   blk_type q_data;

   always_ff @(posedge clock) begin
      if (reset) dir_ff <= 1'b0;
      else if (csr_we) dir_ff <= csr_wdata[0];
   end

   pfd10_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .in_re(req.sample_re), .in_im(req.sample_im), .dir(dir_ff),
      .q_valid, .q_pop, .q_data);

   pfd10_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_idx(rsp.bin_index),
      .out_re(rsp.out_re), .out_im(rsp.out_im), .out_last(rsp.last));
endmodule
`default_nettype wire

// ----- rtl/pfd10_front.sv -----
// Front end: collects ten samples into a block and pushes it to a two-deep queue.
// Depends on pfd10_pkg and prime_factor_dft10_top_macros.svh.
`default_nettype none
module pfd10_front #(parameter int SAMPLE_BITS = 16) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [15:0]           in_re,
   input  wire logic [15:0]           in_im,
   input  wire logic                  dir,
   output logic                       q_valid,
   input  wire logic                  q_pop,
   output pfd10_pkg::blk_type         q_data
);
   import pfd10_pkg::*;
   `include "prime_factor_dft10_top_macros.svh"

   logic [NPTS-1:0][47:0] load_ff;
   logic [3:0] cnt_ff, cnt_in;
   blk_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] fill_ff, fill_in;
   logic take, push;
   logic signed [23:0] ext_re, ext_im;

   // samples wider than the port: the 16-bit field is taken as positive
   if (SAMPLE_BITS > 16) begin : g_wide
      assign ext_re = {8'd0, in_re};
      assign ext_im = {8'd0, in_im};
   end else begin : g_narrow
      assign ext_re = 24'(signed'(in_re[SAMPLE_BITS-1:0]));
      assign ext_im = 24'(signed'(in_im[SAMPLE_BITS-1:0]));
   end
   // last sample of a block waits for queue room
   assign in_ready = (cnt_ff != 4'(NPTS-1)) || (fill_ff != 2'd2);
   assign take = in_valid && in_ready;
   assign push = take && (cnt_ff == 4'(NPTS-1));
   assign cnt_in = push ? 4'd0 : (take ? cnt_ff + 4'd1 : cnt_ff);
   assign fill_in = fill_ff + {1'b0, push} - {1'b0, q_pop};
   assign q_valid = fill_ff != 2'd0;
   assign q_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (take) load_ff[cnt_ff] <= {ext_re, ext_im};
      if (push) begin
         mem_ff[wp_ff].inv <= dir;
         for (int k = 0; k < NPTS-1; k++) mem_ff[wp_ff].smp[k] <= load_ff[k];
         mem_ff[wp_ff].smp[NPTS-1] <= {ext_re, ext_im};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; fill_ff <= '0; wp_ff <= 1'b0; rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; fill_ff <= fill_in;
         if (push) wp_ff <= ~wp_ff;
         if (q_pop) rp_ff <= ~rp_ff;
      end
   end

   `PFD_ASSERT_IMP(a_cnt_rng, clock, reset, 1'b1, cnt_ff < 4'(NPTS), "load count out of range")
   `PFD_ASSERT_IMP(a_no_ovf, clock, reset, push, fill_ff != 2'd2 || q_pop, "queue overflow")
   `PFD_ASSERT_IMP(a_no_udf, clock, reset, q_pop, fill_ff != 2'd0, "queue underflow")
endmodule
`default_nettype wire

// ----- rtl/pfd10_back.sv -----
// Back end: sequenced 5-point/2-point DFTs and result streaming.
// Depends on pfd10_pkg and prime_factor_dft10_top_macros.svh.
`default_nettype none
module pfd10_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_pop,
   input  wire pfd10_pkg::blk_type    q_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [3:0]                 out_idx,
   output logic [19:0]                out_re,
   output logic [19:0]                out_im,
   output logic                       out_last
);
   import pfd10_pkg::*;
   `include "prime_factor_dft10_top_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_D5 = 4'b0010, S_COMB = 4'b0100, S_OUT = 4'b1000
   } st_type;

   st_type st_ff, st_in;
   logic inv_ff;
   logic [NPTS-1:0][47:0] blk_ff;
   logic signed [ACC_BITS-1:0] fr_ff [2][5], fi_ff [2][5];
   logic [19:0] wre_ff [NPTS], wim_ff [NPTS];
   logic half_ff;          // which 5-point DFT
   logic [2:0] ph_ff;      // step inside a 5-point DFT / combine
   logic [3:0] oc_ff;
   logic [3:0] src_ix;
   logic signed [ACC_BITS-1:0] xr [5], xi [5];
   logic signed [ACC_BITS-1:0] t1r, t1i, t2r, t2i, t3r, t3i, t4r, t4i;
   logic signed [47:0] pa, pb, pc, pd;
   logic signed [47:0] ar_ff, ai_ff, br_ff, bi_ff, ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [ACC_BITS-1:0] a1r, a1i, b1r, b1i, a2r, a2i, b2r, b2i;
   logic signed [ACC_BITS-1:0] sr, si, dr, di;
   logic [19:0] o0r, o0i, o1r, o1i;
   logic [3:0] k0, k1;

   function automatic logic signed [ACC_BITS-1:0] rq15(input logic signed [47:0] s);
      logic signed [47:0] y;
      y = s + 48'sd16384;
      return ACC_BITS'(y >>> 15);
   endfunction
   function automatic logic [19:0] sat20(input logic signed [ACC_BITS-1:0] v);
      logic [19:0] r;
      if (v > ACC_BITS'(OUT_MAX)) r = OUT_MAX;
      else if (v < ACC_BITS'(OUT_MIN)) r = OUT_MIN;
      else r = v[19:0];
      return r;
   endfunction
   // round to nearest, ties away from zero, by constant ten
   function automatic logic signed [ACC_BITS-1:0] div10(input logic signed [ACC_BITS-1:0] v);
      logic [ACC_BITS-1:0] m;
      logic [ACC_BITS+24:0] p;
      logic [ACC_BITS-1:0] q;
      logic [ACC_BITS-1:0] rem;
      m = v[ACC_BITS-1] ? ACC_BITS'(-v) + ACC_BITS'(5) : v + ACC_BITS'(5);
      p = (ACC_BITS+25)'(m) * (ACC_BITS+25)'(25'd3355444);
      q = ACC_BITS'(p >> 25);
      rem = m - q * ACC_BITS'(10);
      if (rem >= ACC_BITS'(10)) q = q + 1'b1;
      return v[ACC_BITS-1] ? -signed'(q) : signed'(q);
   endfunction

   // Ruritanian input map
   always_comb begin
      src_ix = '0;
      for (int j = 0; j < 5; j++) begin
         src_ix = half_ff ? 4'((5 + 2*j) % NPTS) : 4'((2*j) % NPTS);
         xr[j] = ACC_BITS'(signed'(blk_ff[src_ix][47:24]));
         xi[j] = inv_ff ? -ACC_BITS'(signed'(blk_ff[src_ix][23:0])) : '0;
      end
      t1r = xr[1] + xr[4]; t1i = xi[1] + xi[4];
      t2r = xr[2] + xr[3]; t2i = xi[2] + xi[3];
      t3r = xr[1] - xr[4]; t3i = xi[1] - xi[4];
      t4r = xr[2] - xr[3]; t4i = xi[2] - xi[3];
   end

   // one step of the 5-point DFT: four products a cycle
   always_comb begin
      case (ph_ff)
         3'd0: begin pa = Q_C72 * t1r; pb = Q_C144 * t2r; pc = Q_C72 * t1i; pd = Q_C144 * t2i; end
         3'd1: begin pa = Q_C144 * t1r; pb = Q_C72 * t2r; pc = Q_C144 * t1i; pd = Q_C72 * t2i; end
         3'd2: begin pa = Q_S72 * t3r; pb = Q_S144 * t4r; pc = Q_S72 * t3i; pd = Q_S144 * t4i; end
         default: begin pa = Q_S144 * t3r; pb = -(Q_S72 * t4r); pc = Q_S144 * t3i;
                        pd = -(Q_S72 * t4i); end
      endcase
      a1r = rq15(ar_ff); a1i = rq15(ai_ff); a2r = rq15(ar2_ff); a2i = rq15(ai2_ff);
      b1r = rq15(br_ff); b1i = rq15(bi_ff); b2r = rq15(br2_ff); b2i = rq15(bi2_ff);
   end

   // CRT output map, one pair per cycle: bins 6*j and 6*j+5, mod ten
   always_comb begin
      sr = fr_ff[0][ph_ff] + fr_ff[1][ph_ff]; si = fi_ff[0][ph_ff] + fi_ff[1][ph_ff];
      dr = fr_ff[0][ph_ff] - fr_ff[1][ph_ff]; di = fi_ff[0][ph_ff] - fi_ff[1][ph_ff];
      unique case (ph_ff)
         3'd0: begin k0 = 4'd0; k1 = 4'd5; end
         3'd1: begin k0 = 4'd6; k1 = 4'd1; end
         3'd2: begin k0 = 4'd2; k1 = 4'd7; end
         3'd3: begin k0 = 4'd8; k1 = 4'd3; end
         default: begin k0 = 4'd4; k1 = 4'd9; end
      endcase
      o0r = inv_ff ? sat20(div10(sr)) : sat20(sr);
      o0i = inv_ff ? '0 : sat20(si);
      o1r = inv_ff ? sat20(div10(dr)) : sat20(dr);
      o1i = inv_ff ? '0 : sat20(di);
   end

   always_comb begin
      st_in = st_ff;
      q_pop = 1'b0;
      unique case (st_ff)
         S_IDLE: if (q_valid) begin q_pop = 1'b1; st_in = S_D5; end
         S_D5:   if (ph_ff == 3'd4 && half_ff) st_in = S_COMB;
         S_COMB: if (ph_ff == 3'd4) st_in = S_OUT;
         S_OUT:  if (out_ready && oc_ff == 4'(NPTS-1)) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   assign out_valid = st_ff == S_OUT;
   assign out_idx = oc_ff;
   assign out_re = wre_ff[oc_ff];
   assign out_im = wim_ff[oc_ff];
   assign out_last = oc_ff == 4'(NPTS-1);

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE && q_valid) begin
         blk_ff <= q_data.smp; inv_ff <= q_data.inv;
      end
      if (st_ff == S_D5) begin
         case (ph_ff)
            3'd0: begin ar_ff <= pa + pb; ai_ff <= pc + pd; end
            3'd1: begin ar2_ff <= pa + pb; ai2_ff <= pc + pd; end
            3'd2: begin br_ff <= pa + pb; bi_ff <= pc + pd; end
            3'd3: begin br2_ff <= pa + pb; bi2_ff <= pc + pd; end
            default: begin
               fr_ff[half_ff][0] <= xr[0] + t1r + t2r;
               fi_ff[half_ff][0] <= xi[0] + t1i + t2i;
               fr_ff[half_ff][1] <= xr[0] + a1r + b1i; fi_ff[half_ff][1] <= xi[0] + a1i - b1r;
               fr_ff[half_ff][4] <= xr[0] + a1r - b1i; fi_ff[half_ff][4] <= xi[0] + a1i + b1r;
               fr_ff[half_ff][2] <= xr[0] + a2r + b2i; fi_ff[half_ff][2] <= xi[0] + a2i - b2r;
               fr_ff[half_ff][3] <= xr[0] + a2r - b2i; fi_ff[half_ff][3] <= xi[0] + a2i + b2r;
            end
         endcase
      end
      if (st_ff == S_COMB) begin
         wre_ff[k0] <= o0r; wim_ff[k0] <= o0i;
         wre_ff[k1] <= o1r; wim_ff[k1] <= o1i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= '0; half_ff <= 1'b0; oc_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_D5 || st_ff == S_COMB)
            ph_ff <= (ph_ff == 3'd4) ? 3'd0 : ph_ff + 3'd1;
         if (st_ff == S_D5 && ph_ff == 3'd4) half_ff <= ~half_ff;
         if (out_valid && out_ready) oc_ff <= out_last ? 4'd0 : oc_ff + 4'd1;
      end
   end

   `PFD_ASSERT_IMP(a_oc_rng, clock, reset, out_valid, oc_ff < 4'(NPTS), "bin index out of range")
   `PFD_ASSERT_NXT(a_pop_start, clock, reset, q_pop, st_ff == S_D5 && ph_ff == 3'd0, "bad start")
   `PFD_ASSERT_IMP(a_ph_rng, clock, reset, 1'b1, ph_ff <= 3'd4, "phase out of range")
endmodule
`default_nettype wire
